// ===== sv/drqa_pkg.sv =====
// Package: constants and codes for the domain resource quota accounting block.
package drqa_pkg;
    localparam int DOMAINS_DEF = 16;
    localparam int AMT_W = 48;

    localparam logic [1:0] CMD_CHECK   = 2'd0;
    localparam logic [1:0] CMD_CONSUME = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_SETLIM  = 2'd3;

    localparam logic [1:0] RES_MEM = 2'd0;
    localparam logic [1:0] RES_THR = 2'd1;
    localparam logic [1:0] RES_CAP = 2'd2;
    localparam logic [1:0] RES_CPU = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_WARN   = 3'd1;
    localparam logic [2:0] ST_CRIT   = 3'd2;
    localparam logic [2:0] ST_EXCEED = 3'd3;
    localparam logic [2:0] ST_BADDOM = 3'd4;

    localparam logic [AMT_W-1:0] CPU_SCALE = 48'd1000000;
    // ceil(2^56 / 15625): (t >> 6) * CPU_RECIP >> 56 == t / 1000000 for any 48-bit t
    localparam logic [42:0] CPU_RECIP = 43'h431_BDE8_2D7C;
endpackage

// ===== sv/domain_resource_quota_accounting.sv =====
// Top level: per-domain resource quota table with check/consume/release/set-limit.
// Usage: drive a command word with start high; it is taken at an edge where busy is low.
// busy then stays high until the result word shows on o_status, o_available and
// o_usage_percent with o_valid high for exactly one cycle; busy is already low in that
// cycle, so the next word can be taken at the edge that ends it. The receiver cannot
// stall; each result is presented once.
// An invalid domain is answered after the memory read and grading; release and
// set-limit also register their write-back. Check and consume read the used/limit
// memories, then run a serial restoring divide of used*100 by the limit; for CPU,
// four partial products first turn used time into seconds by reciprocal multiplication.
// The serial divide sets the pace: a new word is taken only when the last one is done.
// Used counts live in one synchronous memory and limits in another, one entry per
// domain and resource. Reset (synchronous, i_rst_n low) starts a clearing pass that
// zeroes one entry per cycle across all ENT entries, 64 by default, busy high.
// Only one word is in flight and its write-back lands before the next read, so no
// forwarding is needed.
module domain_resource_quota_accounting #(
    parameter int DOMAINS = drqa_pkg::DOMAINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_domain,
    input  logic [1:0]  i_resource,
    input  logic [47:0] i_amount,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [47:0] o_available,
    output logic [7:0]  o_usage_percent
);
    localparam int DW = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
    localparam int ENT = 4 << DW;
    localparam int AW = DW + 2;
    localparam int NW = 56; // width of used*100
    localparam logic [42:0] RECIP = drqa_pkg::CPU_RECIP;

    localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CPU = 3'd2, S_DIV = 3'd3,
                           S_GRADE = 3'd4, S_OUT = 3'd5, S_FIN = 3'd6, S_CLR = 3'd7;

    logic [47:0] used_mem [ENT];
    logic [47:0] lim_mem  [ENT];

    logic [2:0]  r_st;
    logic [1:0]  r_cmd, r_res;
    logic [AW-1:0] r_addr;
    logic [47:0] r_amt;
    logic        r_bad;
    logic [47:0] r_used_rd, r_lim_rd;
    logic [47:0] r_used, r_lim;   // graded values
    logic [NW-1:0] r_q;
    logic [NW-1:0] r_rem;
    logic [84:0] r_acc;
    logic [5:0]  r_cnt;
    logic        r_valid;
    logic [2:0]  r_status;
    logic [47:0] r_avail;
    logic [7:0]  r_pct;
    logic        r_we_u, r_we_l;
    logic [47:0] r_wd;

    wire [47:0] used_q = r_used_rd;
    wire [47:0] lim_q  = r_lim_rd;
    wire        mem_clr = (r_st == S_CLR) && i_rst_n;

    always_ff @(posedge i_clk) begin
        r_used_rd <= used_mem[r_addr];
        r_lim_rd  <= lim_mem[r_addr];
        if (r_we_u || mem_clr) used_mem[r_addr] <= mem_clr ? 48'd0 : r_wd;
        if (r_we_l || mem_clr) lim_mem[r_addr] <= mem_clr ? 48'd0 : r_wd;
    end

    logic [NW-1:0] used100;
    logic [47:0]   div_lim;
    logic [NW:0]   rem_sh, div_ext, rem_sub;
    logic [47:0]   av;
    logic [2:0]    gst;
    logic [47:0]   wd;
    logic          wu, wl;
    logic [20:0]   mul_a;
    logic [21:0]   mul_b;
    logic [42:0]   pp;
    logic [84:0]   pp_sh, acc_n;
    assign used100 = {8'd0, r_used} * NW'(100);
    assign av = (r_lim > r_used) ? r_lim - r_used : 48'd0;
    assign div_lim = (r_lim == 48'd0) ? 48'd1 : r_lim;
    assign rem_sh = {r_rem, r_q[NW-1]};
    assign div_ext = {9'd0, div_lim};
    assign rem_sub = rem_sh - div_ext;

    // used time / 1000000 as (t >> 6) * RECIP >> 56, one 21x22 partial product per cycle
    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                mul_a = used_q[26:6]; mul_b = {1'b0, RECIP[20:0]};
            end
            2'd1: begin
                mul_a = used_q[26:6]; mul_b = RECIP[42:21];
            end
            2'd2: begin
                mul_a = used_q[47:27]; mul_b = {1'b0, RECIP[20:0]};
            end
            default: begin
                mul_a = used_q[47:27]; mul_b = RECIP[42:21];
            end
        endcase
    end
    assign pp = {22'd0, mul_a} * {21'd0, mul_b};
    always_comb begin
        case (r_cnt[1:0])
            2'd0: pp_sh = {42'd0, pp};
            2'd1: pp_sh = {21'd0, pp, 21'd0};
            2'd2: pp_sh = {21'd0, pp, 21'd0};
            default: pp_sh = {pp, 42'd0};
        endcase
    end
    assign acc_n = r_acc + pp_sh;

    always_comb begin
        if (r_amt > av) gst = drqa_pkg::ST_EXCEED;
        else if (r_q >= NW'(95)) gst = drqa_pkg::ST_CRIT;
        else if (r_q >= NW'(80)) gst = drqa_pkg::ST_WARN;
        else gst = drqa_pkg::ST_OK;
    end

    // write-back value for consume/release/set-limit
    always_comb begin
        wd = used_q; wu = 1'b0; wl = 1'b0;
        case (r_cmd)
            drqa_pkg::CMD_CONSUME: begin
                wu = (gst != drqa_pkg::ST_EXCEED);
                if (r_res == drqa_pkg::RES_MEM || r_res == drqa_pkg::RES_CPU)
                    wd = used_q + r_amt;
                else
                    wd = (used_q[31:0] == 32'hFFFF_FFFF) ? used_q : used_q + 48'd1;
            end
            drqa_pkg::CMD_RELEASE: begin
                wu = (r_res != drqa_pkg::RES_CPU);
                if (r_res == drqa_pkg::RES_MEM)
                    wd = (used_q >= r_amt) ? used_q - r_amt : 48'd0;
                else
                    wd = (used_q != 48'd0) ? used_q - 48'd1 : 48'd0;
            end
            drqa_pkg::CMD_SETLIM: begin
                wl = 1'b1;
                case (r_res)
                    drqa_pkg::RES_MEM: wd = r_amt;
                    drqa_pkg::RES_THR, drqa_pkg::RES_CAP: wd = {16'd0, r_amt[31:0]};
                    default: wd = {40'd0, r_amt[7:0]};
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_valid <= 1'b0;
        r_we_u <= 1'b0;
        r_we_l <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_addr <= '0;
        end else begin
            case (r_st)
                S_CLR: begin
                    if (r_addr == AW'(ENT - 1)) r_st <= S_IDLE;
                    r_addr <= r_addr + 1'b1;
                end
                S_IDLE: if (start) begin
                    r_cmd <= i_command;
                    r_res <= i_resource;
                    r_amt <= i_amount;
                    r_bad <= ({24'd0, i_domain} >= 32'(DOMAINS));
                    r_addr <= {i_domain[DW-1:0], i_resource};
                    r_st <= S_RD;
                end
                S_RD: r_st <= S_GRADE; // memory read in flight
                S_GRADE: begin
                    if (r_bad) begin
                        r_status <= drqa_pkg::ST_BADDOM;
                        r_avail <= '0; r_pct <= '0;
                        r_valid <= 1'b1;
                        r_st <= S_IDLE;
                    end else if (r_cmd == drqa_pkg::CMD_RELEASE ||
                                 r_cmd == drqa_pkg::CMD_SETLIM) begin
                        r_we_u <= wu; r_we_l <= wl; r_wd <= wd;
                        r_status <= drqa_pkg::ST_OK;
                        r_avail <= '0; r_pct <= '0;
                        r_st <= S_OUT;
                    end else if (r_res == drqa_pkg::RES_CPU) begin
                        r_lim <= {lim_q[44:0], 3'd0} + {lim_q[46:0], 1'b0};
                        r_acc <= '0;
                        r_cnt <= 6'd0;
                        r_st <= S_CPU;
                    end else begin
                        r_used <= used_q;
                        r_lim <= lim_q;
                        r_cnt <= 6'd56;
                        r_st <= S_DIV;
                    end
                end
                S_CPU: begin
                    r_acc <= acc_n;
                    if (r_cnt == 6'd3) begin
                        r_used <= {19'd0, acc_n[84:56]};
                        r_cnt <= 6'd56;
                        r_st <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 6'd56) begin
                        r_q <= used100;
                        r_rem <= '0;
                        r_cnt <= r_cnt - 6'd1;
                    end else begin
                        if (rem_sh >= div_ext) begin
                            r_rem <= rem_sub[NW-1:0];
                            r_q <= {r_q[NW-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[NW-1:0];
                            r_q <= {r_q[NW-2:0], 1'b0};
                        end
                        if (r_cnt == 6'd0) r_st <= S_FIN;
                        else r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_FIN: begin
                    r_status <= (r_cmd == drqa_pkg::CMD_CONSUME &&
                                 gst != drqa_pkg::ST_EXCEED) ? drqa_pkg::ST_OK : gst;
                    r_avail <= av;
                    r_pct <= (r_q > NW'(255)) ? 8'hFF : r_q[7:0];
                    r_we_u <= wu; r_we_l <= 1'b0; r_wd <= wd;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_st != S_IDLE);
    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_available = r_avail;
    assign o_usage_percent = r_pct;

`ifndef SYNTH
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result held");
    a_bad_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == drqa_pkg::ST_BADDOM) |-> o_available == 48'd0)
        else $error("bad domain with data");
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("word taken without busy");
`endif
endmodule

// ===== sim/domain_resource_quota_accounting_test.sv =====
// Testbench: random and directed command words against a behavioral quota table.
`timescale 1ns / 1ps

module domain_resource_quota_accounting_test;
    localparam int NDOM = drqa_pkg::DOMAINS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  domain;
        logic [1:0]  resource;
        logic [47:0] amount;
        logic        hold;   // wait for all results before sending
    } t_quota_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] available;
        logic [7:0]  percent;
    } t_quota_rsp;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [7:0]  i_domain;
    logic [1:0]  i_resource;
    logic [47:0] i_amount;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [47:0] o_available;
    logic [7:0]  o_usage_percent;

    domain_resource_quota_accounting DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_domain(i_domain), .i_resource(i_resource),
        .i_amount(i_amount), .o_valid(o_valid), .o_status(o_status),
        .o_available(o_available), .o_usage_percent(o_usage_percent)
    );

    logic [47:0] mem_used [NDOM];
    logic [31:0] thr_used [NDOM];
    logic [31:0] caps_cnt [NDOM];
    logic [47:0] cpu_used [NDOM];
    logic [47:0] mem_lim  [NDOM];
    logic [31:0] thr_lim  [NDOM];
    logic [31:0] cap_lim  [NDOM];
    logic [7:0]  cpu_lim  [NDOM];

    t_quota_cmd pending_words[$];
    t_quota_rsp expected_rsp[$];
    bit         failed;
    bit         stim_done;
    int         idle_cycles;
    int         gap_left;
    int         burst_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Returns grade and fills available / saturated percent.
    function automatic logic [2:0] grade_request(int d, logic [1:0] res, logic [47:0] amt,
                                                 output logic [47:0] avail,
                                                 output logic [7:0] pct);
        logic [63:0] used, lim, av, p;
        case (res)
            drqa_pkg::RES_MEM: begin used = mem_used[d]; lim = mem_lim[d]; end
            drqa_pkg::RES_THR: begin used = thr_used[d]; lim = thr_lim[d]; end
            drqa_pkg::RES_CAP: begin used = caps_cnt[d]; lim = cap_lim[d]; end
            default: begin
                used = cpu_used[d] / 64'(drqa_pkg::CPU_SCALE);
                lim = cpu_lim[d] * 64'd10;
            end
        endcase
        av = (lim > used) ? lim - used : 64'd0;
        // used*100 fits: used < 2^48
        p = (used * 64'd100) / (lim > 0 ? lim : 64'd1);
        avail = av[47:0];
        pct = (p > 255) ? 8'd255 : p[7:0];
        if (amt > av) return drqa_pkg::ST_EXCEED;
        if (p >= 95) return drqa_pkg::ST_CRIT;
        if (p >= 80) return drqa_pkg::ST_WARN;
        return drqa_pkg::ST_OK;
    endfunction

    function automatic t_quota_rsp apply_word(t_quota_cmd w);
        t_quota_rsp r;
        int d;
        r = '0;
        if (w.domain >= NDOM) begin
            r.status = drqa_pkg::ST_BADDOM;
            return r;
        end
        d = w.domain;
        case (w.command)
            drqa_pkg::CMD_CHECK:
                r.status = grade_request(d, w.resource, w.amount, r.available, r.percent);
            drqa_pkg::CMD_CONSUME: begin
                r.status = grade_request(d, w.resource, w.amount, r.available, r.percent);
                if (r.status != drqa_pkg::ST_EXCEED) begin
                    r.status = drqa_pkg::ST_OK;
                    case (w.resource)
                        drqa_pkg::RES_MEM: mem_used[d] = mem_used[d] + w.amount;
                        drqa_pkg::RES_THR:
                            if (thr_used[d] != '1) thr_used[d] = thr_used[d] + 32'd1;
                        drqa_pkg::RES_CAP:
                            if (caps_cnt[d] != '1) caps_cnt[d] = caps_cnt[d] + 32'd1;
                        default: cpu_used[d] = cpu_used[d] + w.amount;
                    endcase
                end
            end
            drqa_pkg::CMD_RELEASE: begin
                case (w.resource)
                    drqa_pkg::RES_MEM: mem_used[d] = (mem_used[d] >= w.amount) ?
                                                     mem_used[d] - w.amount : '0;
                    drqa_pkg::RES_THR:
                        if (thr_used[d] != 0) thr_used[d] = thr_used[d] - 32'd1;
                    drqa_pkg::RES_CAP:
                        if (caps_cnt[d] != 0) caps_cnt[d] = caps_cnt[d] - 32'd1;
                    default: ;
                endcase
            end
            default: begin
                case (w.resource)
                    drqa_pkg::RES_MEM: mem_lim[d] = w.amount;
                    drqa_pkg::RES_THR: thr_lim[d] = w.amount[31:0];
                    drqa_pkg::RES_CAP: cap_lim[d] = w.amount[31:0];
                    default: cpu_lim[d] = w.amount[7:0];
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [47:0] rand_amount();
        case ($urandom_range(0, 5))
            0: return 48'({$urandom, $urandom});
            1: return 48'($urandom_range(0, 20));
            2: return 48'($urandom_range(0, 3000));
            3: return 48'($urandom) * 48'($urandom_range(1, 300));
            4: return '1;
            default: return 48'($urandom_range(0, 100));
        endcase
    endfunction

    task automatic add_word(logic [1:0] c, logic [7:0] d, logic [1:0] r,
                            logic [47:0] a, bit h = 0);
        t_quota_cmd w;
        w.command = c; w.domain = d; w.resource = r; w.amount = a; w.hold = h;
        pending_words.push_back(w);
    endtask

    initial begin
        int d, k;
        logic [1:0] r;
        for (int i = 0; i < NDOM; i++) begin
            mem_used[i] = '0; thr_used[i] = '0; caps_cnt[i] = '0; cpu_used[i] = '0;
            mem_lim[i] = '0; thr_lim[i] = '0; cap_lim[i] = '0; cpu_lim[i] = '0;
        end
        // directed: extremes, each command, invalid domains, saturation
        add_word(drqa_pkg::CMD_CHECK, 8'd0, drqa_pkg::RES_MEM, 48'd0);
        add_word(drqa_pkg::CMD_CONSUME, 8'd0, drqa_pkg::RES_THR, 48'd0);
        add_word(drqa_pkg::CMD_CHECK, 8'd0, drqa_pkg::RES_THR, 48'd1);
        add_word(drqa_pkg::CMD_CONSUME, 8'd255, drqa_pkg::RES_MEM, '1);
        add_word(drqa_pkg::CMD_SETLIM, 8'd16, drqa_pkg::RES_CPU, 48'd5);
        add_word(drqa_pkg::CMD_SETLIM, 8'd15, drqa_pkg::RES_MEM, '1);
        add_word(drqa_pkg::CMD_CONSUME, 8'd15, drqa_pkg::RES_MEM, 48'hFFFF_FFFF_FFF0);
        add_word(drqa_pkg::CMD_CHECK, 8'd15, drqa_pkg::RES_MEM, 48'd15);
        add_word(drqa_pkg::CMD_CHECK, 8'd15, drqa_pkg::RES_MEM, 48'd16);
        add_word(drqa_pkg::CMD_RELEASE, 8'd15, drqa_pkg::RES_MEM, '1);
        add_word(drqa_pkg::CMD_SETLIM, 8'd1, drqa_pkg::RES_THR, 48'hAB_FFFF_FFFF);
        add_word(drqa_pkg::CMD_SETLIM, 8'd1, drqa_pkg::RES_CAP, 48'd10);
        add_word(drqa_pkg::CMD_CONSUME, 8'd1, drqa_pkg::RES_CAP, 48'd1);
        add_word(drqa_pkg::CMD_RELEASE, 8'd1, drqa_pkg::RES_CAP, 48'd0);
        add_word(drqa_pkg::CMD_RELEASE, 8'd1, drqa_pkg::RES_CAP, 48'd0);
        add_word(drqa_pkg::CMD_SETLIM, 8'd2, drqa_pkg::RES_CPU, 48'h1FF);
        add_word(drqa_pkg::CMD_CONSUME, 8'd2, drqa_pkg::RES_CPU, 48'd2_550_000_000);
        add_word(drqa_pkg::CMD_CHECK, 8'd2, drqa_pkg::RES_CPU, 48'd0);
        add_word(drqa_pkg::CMD_RELEASE, 8'd2, drqa_pkg::RES_CPU, 48'd7);
        add_word(drqa_pkg::CMD_SETLIM, 8'd2, drqa_pkg::RES_CPU, 48'd0);
        add_word(drqa_pkg::CMD_CHECK, 8'd2, drqa_pkg::RES_CPU, 48'd0, 1);
        add_word(drqa_pkg::CMD_SETLIM, 8'd3, drqa_pkg::RES_MEM, 48'd100);
        add_word(drqa_pkg::CMD_CONSUME, 8'd3, drqa_pkg::RES_MEM, 48'd85);
        add_word(drqa_pkg::CMD_CHECK, 8'd3, drqa_pkg::RES_MEM, 48'd0);
        add_word(drqa_pkg::CMD_CONSUME, 8'd3, drqa_pkg::RES_MEM, 48'd12);
        // random: mostly valid domains, with amounts and limits of mixed size so grades vary
        for (int n = 0; n < 1400; n++) begin
            d = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 255) : $urandom_range(0, 15);
            r = 2'($urandom_range(0, 3));
            k = $urandom_range(0, 9);
            if (k < 2) add_word(drqa_pkg::CMD_SETLIM, d[7:0], r, rand_amount(), n == 700);
            else if (k < 4)
                add_word(drqa_pkg::CMD_CHECK, d[7:0], r, rand_amount(), n == 700);
            else if (k < 8) add_word(drqa_pkg::CMD_CONSUME, d[7:0], r,
                                     (r == drqa_pkg::RES_CPU && $urandom_range(0, 1)) ?
                                     48'($urandom_range(0, 900)) * 48'd1000000 :
                                     rand_amount(), n == 700);
            else add_word(drqa_pkg::CMD_RELEASE, d[7:0], r, rand_amount(), n == 700);
        end
        stim_done = 1'b1;
    end

    initial begin
        failed = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        t_quota_cmd w;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_command <= '0; i_domain <= '0; i_resource <= '0; i_amount <= '0;
            gap_left <= 0;
            burst_left <= 0;
        end else if (start && busy) begin
            // word not yet taken; keep it on the ports
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].hold && (expected_rsp.size() > 0 || busy
                                                 || start))) begin
            w = pending_words.pop_front();
            expected_rsp.push_back(apply_word(w));
            start <= 1'b1;
            i_command <= w.command; i_domain <= w.domain;
            i_resource <= w.resource; i_amount <= w.amount;
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(0, 12);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_quota_rsp e;
        if (i_rst_n && o_valid) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t unexpected word: status %0d avail %0h pct %0d", $time,
                         o_status, o_available, o_usage_percent);
                failed = 1'b1;
            end else begin
                e = expected_rsp.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t status exp %0d got %0d", $time, e.status, o_status);
                    failed = 1'b1;
                end
                if (o_available !== e.available) begin
                    $display("%0t available exp %0h got %0h", $time, e.available,
                             o_available);
                    failed = 1'b1;
                end
                if (o_usage_percent !== e.percent) begin
                    $display("%0t percent exp %0d got %0d", $time, e.percent,
                             o_usage_percent);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog and end of run
    initial begin
        idle_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid || (start && !busy)) idle_cycles = 0;
            else idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("domain_resource_quota_accounting: mismatch");
                $finish;
            end
            if (stim_done && pending_words.size() == 0 && !start
                && expected_rsp.size() == 0) begin
                repeat (200) @(posedge i_clk);
                if (!failed && expected_rsp.size() == 0) begin
                    $display("domain_resource_quota_accounting: match");
                end else begin
                    $display("domain_resource_quota_accounting: mismatch");
                end
                $finish;
            end
        end
    end
endmodule
